FILE: design/ntg_pkg.sv
// package: shared types, constants and reset values for the twiddle generator
`timescale 1ns / 1ps

package ntg_pkg;

    localparam int DEF_EXPONENT_BITS = 9;
    localparam int DATA_W            = 32;
    localparam int MOD_W             = 31;
    localparam int CFG_IDX_W         = 3;
    localparam int PROD_W            = 64;
    localparam int MAG_W             = 63;
    localparam int STEP_W            = 6;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS = 3'd0,
        CFG_ROOT    = 3'd1,
        CFG_MONT    = 3'd2,
        CFG_QINV    = 3'd3,
        CFG_INV_N   = 3'd4
    } cfg_idx_t;

    localparam logic [MOD_W-1:0]         RST_MODULUS = 31'd8380417;
    localparam logic [MOD_W-1:0]         RST_ROOT    = 31'd1753;
    localparam logic signed [DATA_W-1:0] RST_MONT    = -32'sd4186625;
    localparam logic signed [DATA_W-1:0] RST_QINV    = 32'sd58728449;
    localparam logic [MOD_W-1:0]         RST_INV_N   = 31'd8347681;

    typedef struct packed {
        logic [MOD_W-1:0]         modulus;
        logic [MOD_W-1:0]         root;
        logic signed [DATA_W-1:0] mont;
        logic signed [DATA_W-1:0] qinv;
        logic [MOD_W-1:0]         inv_n;
    } cfg_t;

    // operand pairs of the shared modular multiplier
    typedef enum logic [1:0] {
        OP_ACC_BASE = 2'd0,
        OP_BASE_SQR = 2'd1,
        OP_ACC_MONT = 2'd2,
        OP_ACC_INVN = 2'd3
    } mul_op_t;

    typedef struct packed {
        logic    init;
        logic    start;
        mul_op_t op;
        logic    emit;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic mul_busy;
    } dp_status_t;

endpackage

FILE: design/ntg_if.sv
// interfaces: input item channel and result channel
`timescale 1ns / 1ps

interface ntg_item_if #(
    parameter int EXPONENT_BITS = 9
);
    logic                     valid;
    logic                     ready;
    logic [EXPONENT_BITS-1:0] exponent;
    logic                     final_scale;

    modport source (output valid, output exponent, output final_scale, input ready);
    modport sink (input valid, input exponent, input final_scale, output ready);
endinterface

interface ntg_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] zeta;
    logic signed [31:0] zeta_qinv;

    modport source (output valid, output zeta, output zeta_qinv, input ready);
    modport sink (input valid, input zeta, input zeta_qinv, output ready);
endinterface

FILE: design/ntg_datapath.sv
// datapath: power registers, shared multiplier, bit-serial reducer and output registers
`timescale 1ns / 1ps

module ntg_datapath
    import ntg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    output logic signed [DATA_W-1:0] zeta,
    output logic signed [DATA_W-1:0] zeta_qinv
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ABS  = 4'b0010,
        PH_DIV  = 4'b0100,
        PH_FIX  = 4'b1000
    } phase_t;

    phase_t phase_reg, phase_next;

    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] base_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     dest_base_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [MOD_W-1:0]         rem_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [DATA_W-1:0] zeta_reg;
    logic signed [DATA_W-1:0] zq_reg;

    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [PROD_W-1:0] prod;
    logic [DATA_W-1:0]        trial;
    logic [DATA_W-1:0]        mod_ext;
    logic signed [33:0]       r0;
    logic signed [33:0]       r1;
    logic signed [33:0]       r2;
    logic signed [33:0]       half;
    logic signed [33:0]       mod34;
    logic signed [DATA_W-1:0] res;
    logic signed [PROD_W-1:0] zq_full;

    // operand selection and the single multiplier
    always_comb
    begin
        case (cmd.op)
            OP_ACC_BASE:
            begin
                op_a = acc_reg;
                op_b = base_reg;
            end
            OP_BASE_SQR:
            begin
                op_a = base_reg;
                op_b = base_reg;
            end
            OP_ACC_MONT:
            begin
                op_a = acc_reg;
                op_b = cfg.mont;
            end
            default:
            begin
                op_a = acc_reg;
                op_b = $signed({1'b0, cfg.inv_n});
            end
        endcase
        prod = op_a * op_b;
    end

    // one restoring remainder step
    assign mod_ext = {1'b0, cfg.modulus};
    assign trial   = {rem_reg, mag_reg[MAG_W-1]};

    // sign restore and centring
    always_comb
    begin
        mod34 = $signed({3'b000, cfg.modulus});
        half  = $signed({4'b0000, cfg.modulus[MOD_W-1:1]});
        r0    = neg_reg ? -$signed({3'b000, rem_reg}) : $signed({3'b000, rem_reg});
        r1    = (r0 >= half) ? r0 - mod34 : r0;
        r2    = (r1 < -half) ? r1 + mod34 : r1;
        res   = (cfg.modulus == '0) ? '0 : r2[DATA_W-1:0];
    end

    assign zq_full = acc_reg * cfg.qinv;

    // reducer phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: if (cmd.start) phase_next = PH_ABS;
            PH_ABS:  phase_next = PH_DIV;
            PH_DIV:  if (step_reg == '0) phase_next = PH_FIX;
            PH_FIX:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            acc_reg  <= 32'sd1;
            base_reg <= $signed({1'b0, cfg.root});
        end
        if (cmd.start)
        begin
            prod_reg      <= prod;
            dest_base_reg <= (cmd.op == OP_BASE_SQR);
        end
        if (phase_reg == PH_ABS)
        begin
            neg_reg  <= prod_reg[PROD_W-1];
            mag_reg  <= prod_reg[PROD_W-1] ? MAG_W'(-prod_reg) : prod_reg[MAG_W-1:0];
            rem_reg  <= '0;
            step_reg <= STEP_W'(MAG_W - 1);
        end
        if (phase_reg == PH_DIV)
        begin
            rem_reg  <= (trial >= mod_ext) ? MOD_W'(trial - mod_ext) : trial[MOD_W-1:0];
            mag_reg  <= {mag_reg[MAG_W-2:0], 1'b0};
            step_reg <= step_reg - 1'b1;
        end
        if (phase_reg == PH_FIX)
        begin
            if (dest_base_reg)
                base_reg <= res;
            else
                acc_reg <= res;
        end
        if (cmd.emit)
        begin
            zeta_reg <= acc_reg;
            zq_reg   <= zq_full[DATA_W-1:0];
        end
    end

    assign status.mul_done = (phase_reg == PH_FIX);
    assign status.mul_busy = (phase_reg != PH_IDLE);
    assign zeta            = zeta_reg;
    assign zeta_qinv       = zq_reg;

endmodule

FILE: design/ntg_controller.sv
// controller: square-and-multiply and scaling sequence, input and output handshakes
`timescale 1ns / 1ps

module ntg_controller
    import ntg_pkg::*;
#(
    parameter int EXPONENT_BITS = DEF_EXPONENT_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    ntg_item_if.sink   item,
    input  logic       result_ready,
    output logic       result_valid,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_BIT      = 12'b000000000010,
        S_WAIT_MUL = 12'b000000000100,
        S_SQR      = 12'b000000001000,
        S_WAIT_SQR = 12'b000000010000,
        S_MONT1    = 12'b000000100000,
        S_WAIT_M1  = 12'b000001000000,
        S_MONT2    = 12'b000010000000,
        S_WAIT_M2  = 12'b000100000000,
        S_INVN     = 12'b001000000000,
        S_WAIT_INV = 12'b010000000000,
        S_OUT      = 12'b100000000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [EXPONENT_BITS-1:0] exp_reg, exp_next;
    logic                     fin_reg, fin_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     take;

    assign take       = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        exp_next   = exp_reg;
        fin_next   = fin_reg;
        cmd.init   = 1'b0;
        cmd.start  = 1'b0;
        cmd.op     = OP_ACC_BASE;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    cmd.init   = 1'b1;
                    exp_next   = item.exponent;
                    fin_next   = item.final_scale;
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                if (exp_reg == '0)
                begin
                    state_next = S_MONT1;
                end
                else if (exp_reg[0])
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_ACC_BASE;
                    state_next = S_WAIT_MUL;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_BASE_SQR;
                    state_next = S_WAIT_SQR;
                end
            end
            S_WAIT_MUL: if (status.mul_done) state_next = S_SQR;
            S_SQR:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_BASE_SQR;
                state_next = S_WAIT_SQR;
            end
            S_WAIT_SQR:
            begin
                if (status.mul_done)
                begin
                    exp_next   = exp_reg >> 1;
                    state_next = S_BIT;
                end
            end
            S_MONT1:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_ACC_MONT;
                state_next = S_WAIT_M1;
            end
            S_WAIT_M1: if (status.mul_done) state_next = fin_reg ? S_MONT2 : S_OUT;
            S_MONT2:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_ACC_MONT;
                state_next = S_WAIT_M2;
            end
            S_WAIT_M2: if (status.mul_done) state_next = S_INVN;
            S_INVN:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_ACC_INVN;
                state_next = S_WAIT_INV;
            end
            S_WAIT_INV: if (status.mul_done) state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;
        if (cmd.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        fin_reg <= fin_next;
    end

    assign result_valid = out_valid_reg;

    // a finished product only arrives while the sequencer waits for one
    assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_done |-> (state_reg == S_WAIT_MUL || state_reg == S_WAIT_SQR ||
                             state_reg == S_WAIT_M1 || state_reg == S_WAIT_M2 ||
                             state_reg == S_WAIT_INV))
        else $error("reducer finished outside a wait state");

    // a product is never issued while the reducer is still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !status.mul_busy)
        else $error("multiplier issued while reducer busy");

    // an accepted item always starts the exponent walk
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg == S_BIT)
        else $error("accepted item did not start");

    // a result is loaded only into a free or draining output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || result_ready))
        else $error("result overwritten before transfer");

endmodule

FILE: design/ntt_twiddle_generator.sv
// Top level of the twiddle generator: configuration registers, controller and datapath.
// Each modular product runs through issue, magnitude, 63 remainder steps and sign fix/centring.
// An item needs two products per exponent bit up to the highest set bit (one when the bit is
// clear) plus 1 or 3 scaling ones; its result is then loaded into the output register.
// A new item is taken only once the last result has entered the output register; output stalls delay that.
// Reset (rst_n, asynchronous, active low) idles the sequencer, empties the output, loads defaults.
`timescale 1ns / 1ps

module ntt_twiddle_generator
    import ntg_pkg::*;
#(
    parameter int EXPONENT_BITS = DEF_EXPONENT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    ntg_item_if.sink             item,
    ntg_result_if.source         result
);

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       res_valid;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus <= RST_MODULUS;
            cfg_reg.root    <= RST_ROOT;
            cfg_reg.mont    <= RST_MONT;
            cfg_reg.qinv    <= RST_QINV;
            cfg_reg.inv_n   <= RST_INV_N;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODULUS: cfg_reg.modulus <= cfg_wdata[MOD_W-1:0];
                CFG_ROOT:    cfg_reg.root    <= cfg_wdata[MOD_W-1:0];
                CFG_MONT:    cfg_reg.mont    <= $signed(cfg_wdata);
                CFG_QINV:    cfg_reg.qinv    <= $signed(cfg_wdata);
                CFG_INV_N:   cfg_reg.inv_n   <= cfg_wdata[MOD_W-1:0];
                default:     ;
            endcase
        end
    end

    // sequencer
    ntg_controller #(
        .EXPONENT_BITS (EXPONENT_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result_ready (result.ready),
        .result_valid (res_valid),
        .status       (status),
        .cmd          (cmd)
    );

    // arithmetic
    ntg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .zeta      (result.zeta),
        .zeta_qinv (result.zeta_qinv)
    );

    assign result.valid = res_valid;

endmodule
